// ----- design/svpwm_pkg.sv -----
// shared types, widths, constants and arithmetic helpers for the space vector pwm block
// no dependencies
`timescale 1ns / 1ps

package svpwm_pkg;

  localparam int InW        = 16;
  localparam int MagW       = 17;
  localparam int NumW       = 18;
  localparam int DenW       = 16;
  localparam int QuotW      = 34;
  localparam int SumW       = 36;
  localparam int SetW       = 16;
  localparam int SecW       = 3;
  localparam int DcW        = 15;
  localparam int CfgIdxW    = 2;
  localparam int CfgW       = 16;
  localparam int QueueDepth = 4;

  // 1/sqrt3 and 2/sqrt3 in q16
  localparam logic [MagW-1:0] InvSqrt3Q16    = 17'd37837;
  localparam logic [MagW-1:0] TwoInvSqrt3Q16 = 17'd75674;
  localparam logic [SumW-1:0] OneQ16         = 36'd65536;

  localparam logic [CfgIdxW-1:0] CfgDcLink = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPeriod = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPwmMax = 2'd2;

  localparam logic [SecW-1:0] Sec1 = 3'd1;
  localparam logic [SecW-1:0] Sec2 = 3'd2;
  localparam logic [SecW-1:0] Sec3 = 3'd3;
  localparam logic [SecW-1:0] Sec4 = 3'd4;
  localparam logic [SecW-1:0] Sec5 = 3'd5;
  localparam logic [SecW-1:0] Sec6 = 3'd6;

  typedef struct packed {
    logic [SecW-1:0] sector;
    logic [MagW-1:0] ur;
    logic [MagW-1:0] ul;
  } vec_class_t;

  typedef struct packed {
    logic            ge;
    logic [DenW-1:0] rem;
  } div_step_t;

  // one restoring division step
  function automatic div_step_t div_step(input logic [DenW-1:0] rem,
                                         input logic            nbit,
                                         input logic [DenW-1:0] den);
    logic [DenW:0] rem_sh;
    logic [DenW:0] diff;
    div_step_t     r;
    rem_sh = {rem, nbit};
    diff   = rem_sh - {1'b0, den};
    r.ge   = (rem_sh >= {1'b0, den});
    r.rem  = r.ge ? diff[DenW-1:0] : rem_sh[DenW-1:0];
    return r;
  endfunction

  // top * ratio / 65536, clamped to 0..top
  function automatic logic [SetW-1:0] scale_clamp(input logic [SumW-1:0] ratio,
                                                  input logic [SetW-1:0] top);
    logic [2*SetW-1:0] prod;
    logic [SetW-1:0]   res;
    prod = top * ratio[SetW-1:0];
    if (ratio[SumW-1]) begin
      res = '0;
    end else if (|ratio[SumW-2:SetW]) begin
      res = top;
    end else begin
      res = prod[2*SetW-1:SetW];
    end
    return res;
  endfunction

endpackage

// ----- design/svpwm_front.sv -----
// front end: takes alpha/beta vectors, finds the sector and the two active vector magnitudes
// depends on svpwm_pkg
`timescale 1ns / 1ps

module svpwm_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [svpwm_pkg::InW-1:0]  alpha_i,
  input  logic [svpwm_pkg::InW-1:0]  beta_i,
  output logic                       cls_valid_o,
  input  logic                       cls_ready_i,
  output svpwm_pkg::vec_class_t      cls_o
);

  logic                        r1_v_q;
  logic [svpwm_pkg::MagW-1:0]  r1_a_q, r1_b_q;
  logic                        r1_al_neg_q, r1_be_neg_q;
  logic                        r2_v_q;
  svpwm_pkg::vec_class_t       r2_cls_q;
  svpwm_pkg::vec_class_t       cls_d;

  logic                        r1_ready, r2_ready;
  logic [svpwm_pkg::MagW-1:0]  al_ext, be_ext, a_abs, b_abs;
  logic [2*svpwm_pkg::MagW-1:0] prod_p, prod_c;
  logic [svpwm_pkg::MagW-1:0]  p_val, c_val, a_sum, b_abs_diff;
  logic [svpwm_pkg::MagW:0]    b_diff, b_neg;
  logic                        b_pos;

  assign r2_ready  = !r2_v_q || cls_ready_i;
  assign r1_ready  = !r1_v_q || r2_ready;
  assign s_ready_o = r1_ready;

  assign al_ext = {alpha_i[svpwm_pkg::InW-1], alpha_i};
  assign be_ext = {beta_i[svpwm_pkg::InW-1], beta_i};
  assign a_abs  = alpha_i[svpwm_pkg::InW-1] ? (~al_ext + 1'b1) : al_ext;
  assign b_abs  = beta_i[svpwm_pkg::InW-1] ? (~be_ext + 1'b1) : be_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
      r2_v_q <= 1'b0;
    end else begin
      if (r1_ready) r1_v_q <= s_valid_i;
      if (r2_ready) r2_v_q <= r1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1_ready) begin
      r1_a_q      <= a_abs;
      r1_b_q      <= b_abs;
      r1_al_neg_q <= alpha_i[svpwm_pkg::InW-1];
      r1_be_neg_q <= beta_i[svpwm_pkg::InW-1];
    end
    if (r2_ready) r2_cls_q <= cls_d;
  end

  // projections of |beta| onto the sector boundaries
  assign prod_p     = r1_b_q * svpwm_pkg::InvSqrt3Q16;
  assign prod_c     = r1_b_q * svpwm_pkg::TwoInvSqrt3Q16;
  assign p_val      = prod_p[2*svpwm_pkg::MagW-2:16];
  assign c_val      = prod_c[2*svpwm_pkg::MagW-2:16];
  assign a_sum      = r1_a_q + p_val;
  assign b_diff     = {1'b0, r1_a_q} - {1'b0, p_val};
  assign b_neg      = ~b_diff + 1'b1;
  assign b_pos      = !b_diff[svpwm_pkg::MagW];
  assign b_abs_diff = b_pos ? b_diff[svpwm_pkg::MagW-1:0] : b_neg[svpwm_pkg::MagW-1:0];

  always_comb begin
    cls_d.ur = b_abs_diff;
    cls_d.ul = a_sum;
    if (!r1_be_neg_q) begin
      if (!r1_al_neg_q) cls_d.sector = b_pos ? svpwm_pkg::Sec1 : svpwm_pkg::Sec2;
      else              cls_d.sector = b_pos ? svpwm_pkg::Sec3 : svpwm_pkg::Sec2;
    end else begin
      if (!r1_al_neg_q) cls_d.sector = b_pos ? svpwm_pkg::Sec6 : svpwm_pkg::Sec5;
      else              cls_d.sector = b_pos ? svpwm_pkg::Sec4 : svpwm_pkg::Sec5;
    end
    unique case (cls_d.sector)
      svpwm_pkg::Sec1, svpwm_pkg::Sec4: begin
        cls_d.ur = b_abs_diff;
        cls_d.ul = c_val;
      end
      svpwm_pkg::Sec3, svpwm_pkg::Sec6: begin
        cls_d.ur = c_val;
        cls_d.ul = b_abs_diff;
      end
      svpwm_pkg::Sec2: begin
        cls_d.ur = r1_al_neg_q ? b_abs_diff : a_sum;
        cls_d.ul = r1_al_neg_q ? a_sum : b_abs_diff;
      end
      svpwm_pkg::Sec5: begin
        cls_d.ur = r1_al_neg_q ? a_sum : b_abs_diff;
        cls_d.ul = r1_al_neg_q ? b_abs_diff : a_sum;
      end
      default: begin
        cls_d.ur = b_abs_diff;
        cls_d.ul = a_sum;
      end
    endcase
  end

  assign cls_valid_o = r2_v_q;
  assign cls_o       = r2_cls_q;

endmodule

// ----- design/svpwm_fifo.sv -----
// short queue between the classifying front end and the duty back end
// depends on svpwm_pkg
`timescale 1ns / 1ps

module svpwm_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  ready_o,
  input  svpwm_pkg::vec_class_t data_i,
  output logic                  valid_o,
  input  logic                  pop_i,
  output svpwm_pkg::vec_class_t data_o
);

  localparam int PtrW = $clog2(svpwm_pkg::QueueDepth);
  localparam int CntW = $clog2(svpwm_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(svpwm_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(svpwm_pkg::QueueDepth);

  svpwm_pkg::vec_class_t mem_q [svpwm_pkg::QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign ready_o = (cnt_q != FullCnt);
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("queue count past depth");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |=> cnt_q == $past(cnt_q) - 1'b1 || $past(do_push))
    else $error("queue pop lost track of count");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == FullCnt) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

endmodule

// ----- design/svpwm_div.sv -----
// pipelined restoring divider, one quotient bit per stage, takes a new operand every cycle while en_i is high
// depends on svpwm_pkg
`timescale 1ns / 1ps

module svpwm_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [svpwm_pkg::NumW-1:0]   num_i,
  input  logic [svpwm_pkg::DenW-1:0]   den_i,
  output logic [svpwm_pkg::QuotW-1:0]  quot_o
);

  localparam int Steps = svpwm_pkg::QuotW;
  localparam int PadW  = svpwm_pkg::QuotW - svpwm_pkg::NumW;

  // each stage shifts a dividend bit out of the top and a quotient bit in at the bottom
  logic [svpwm_pkg::DenW-1:0]  rem_q [Steps];
  logic [svpwm_pkg::QuotW-1:0] nq_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_stage
    logic [svpwm_pkg::DenW-1:0]  rem_in;
    logic [svpwm_pkg::QuotW-1:0] nq_in;
    svpwm_pkg::div_step_t        st;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = {num_i, {PadW{1'b0}}};
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
    end

    assign st = svpwm_pkg::div_step(rem_in, nq_in[svpwm_pkg::QuotW-1], den_i);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= st.rem;
        nq_q[k]  <= {nq_in[svpwm_pkg::QuotW-2:0], st.ge};
      end
    end
  end

  assign quot_o = nq_q[Steps-1];

endmodule

// ----- design/svpwm_back.sv -----
// back end: on-time ratios by division, zero vector split, setpoint scaling and phase mapping
// depends on svpwm_pkg and svpwm_div
`timescale 1ns / 1ps

module svpwm_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  svpwm_pkg::vec_class_t       q_data_i,
  output logic                        q_pop_o,
  input  logic [svpwm_pkg::DenW-1:0]  den_i,
  input  logic [svpwm_pkg::SetW-1:0]  pwm_max_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [svpwm_pkg::SetW-1:0]  u_o,
  output logic [svpwm_pkg::SetW-1:0]  v_o,
  output logic [svpwm_pkg::SetW-1:0]  w_o,
  output logic [svpwm_pkg::SecW-1:0]  sector_o,
  output logic                        over_o
);

  localparam int Steps = svpwm_pkg::QuotW;
  localparam logic [svpwm_pkg::SumW-1:0] HalfQ16 = 36'd32768;

  logic en;

  logic                         ld_v_q;
  logic [svpwm_pkg::SecW-1:0]   ld_sec_q;
  logic [svpwm_pkg::NumW-1:0]   ld_nr_q, ld_nl_q;

  logic [Steps-1:0]             dv_v_q;
  logic [svpwm_pkg::SecW-1:0]   dv_sec_q [Steps];
  logic [svpwm_pkg::QuotW-1:0]  tr, tl;

  logic                         e1_v_q, e2_v_q, e3_v_q;
  logic [svpwm_pkg::SecW-1:0]   e1_sec_q, e2_sec_q, e3_sec_q;
  logic [svpwm_pkg::SumW-1:0]   e1_diff_q;
  logic [svpwm_pkg::QuotW-1:0]  e1_tm_q, e2_tm_q;
  logic [svpwm_pkg::SumW-1:0]   e2_t0_q, e3_lo_q, e3_mid_q, e3_hi_q;
  logic                         e2_over_q, e3_over_q;
  logic [svpwm_pkg::SumW-1:0]   t0_sum;

  logic                         out_v_q;
  logic [svpwm_pkg::SetW-1:0]   out_u_q, out_v_sp_q, out_w_q;
  logic [svpwm_pkg::SecW-1:0]   out_sec_q;
  logic                         out_over_q;
  logic [svpwm_pkg::SetW-1:0]   s_lo, s_md, s_hi;

  // the whole back pipeline moves unless a finished result is stuck at the output
  assign en      = !out_v_q || out_ready_i;
  assign q_pop_o = en && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_v_q  <= 1'b0;
      dv_v_q  <= '0;
      e1_v_q  <= 1'b0;
      e2_v_q  <= 1'b0;
      e3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      ld_v_q  <= q_valid_i;
      dv_v_q  <= {dv_v_q[Steps-2:0], ld_v_q};
      e1_v_q  <= dv_v_q[Steps-1];
      e2_v_q  <= e1_v_q;
      e3_v_q  <= e2_v_q;
      out_v_q <= e3_v_q;
    end
  end

  // dividend is 3 * magnitude, the divisor 2 * dc link
  always_ff @(posedge clk_i) begin
    if (en) begin
      ld_sec_q <= q_data_i.sector;
      ld_nr_q  <= svpwm_pkg::NumW'(q_data_i.ur) + {q_data_i.ur, 1'b0};
      ld_nl_q  <= svpwm_pkg::NumW'(q_data_i.ul) + {q_data_i.ul, 1'b0};
      dv_sec_q[0] <= ld_sec_q;
      for (int k = 1; k < Steps; k++) dv_sec_q[k] <= dv_sec_q[k-1];
    end
  end

  svpwm_div u_div_r (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (ld_nr_q),
    .den_i  (den_i),
    .quot_o (tr)
  );

  svpwm_div u_div_l (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (ld_nl_q),
    .den_i  (den_i),
    .quot_o (tl)
  );

  // halve toward zero: bias negative values by one before the arithmetic shift
  assign t0_sum = e1_diff_q + svpwm_pkg::SumW'(e1_diff_q[svpwm_pkg::SumW-1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_sec_q  <= dv_sec_q[Steps-1];
      e1_diff_q <= svpwm_pkg::OneQ16 - svpwm_pkg::SumW'(tr) - svpwm_pkg::SumW'(tl);
      e1_tm_q   <= dv_sec_q[Steps-1][0] ? tr : tl;

      e2_sec_q  <= e1_sec_q;
      e2_t0_q   <= {t0_sum[svpwm_pkg::SumW-1], t0_sum[svpwm_pkg::SumW-1:1]};
      e2_tm_q   <= e1_tm_q;
      e2_over_q <= e1_diff_q[svpwm_pkg::SumW-1];

      e3_sec_q  <= e2_sec_q;
      e3_lo_q   <= e2_t0_q;
      e3_mid_q  <= e2_t0_q + svpwm_pkg::SumW'(e2_tm_q);
      e3_hi_q   <= svpwm_pkg::OneQ16 - e2_t0_q;
      e3_over_q <= e2_over_q;
    end
  end

  assign s_lo = svpwm_pkg::scale_clamp(e3_lo_q, pwm_max_i);
  assign s_md = svpwm_pkg::scale_clamp(e3_mid_q, pwm_max_i);
  assign s_hi = svpwm_pkg::scale_clamp(e3_hi_q, pwm_max_i);

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_sec_q  <= e3_sec_q;
      out_over_q <= e3_over_q;
      unique case (e3_sec_q)
        svpwm_pkg::Sec1: begin out_u_q <= s_lo; out_v_sp_q <= s_md; out_w_q <= s_hi; end
        svpwm_pkg::Sec2: begin out_v_sp_q <= s_lo; out_u_q <= s_md; out_w_q <= s_hi; end
        svpwm_pkg::Sec3: begin out_v_sp_q <= s_lo; out_w_q <= s_md; out_u_q <= s_hi; end
        svpwm_pkg::Sec4: begin out_w_q <= s_lo; out_v_sp_q <= s_md; out_u_q <= s_hi; end
        svpwm_pkg::Sec5: begin out_w_q <= s_lo; out_u_q <= s_md; out_v_sp_q <= s_hi; end
        default:         begin out_u_q <= s_lo; out_w_q <= s_md; out_v_sp_q <= s_hi; end
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign u_o         = out_u_q;
  assign v_o         = out_v_sp_q;
  assign w_o         = out_w_q;
  assign sector_o    = out_sec_q;
  assign over_o      = out_over_q;

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e3_v_q && !e3_over_q) |->
      ($signed(e3_lo_q) <= $signed(e3_mid_q) && $signed(e3_mid_q) <= $signed(e3_hi_q)))
    else $error("low/mid/high ordering broken inside the hexagon");
  a_t0_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e2_v_q |-> $signed(e2_t0_q) <= $signed(HalfQ16))
    else $error("zero vector time above half period");
  a_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_sec_q >= svpwm_pkg::Sec1 && out_sec_q <= svpwm_pkg::Sec6))
    else $error("result sector out of range");

endmodule

// ----- design/space_vector_pwm_setpoints.sv -----
// Space vector PWM setpoint generator. Each accepted alpha/beta vector (signed Q8.8 volts) gives
// one result: the sector 1..6, three center-aligned compare values for phases U, V and W scaled
// to pwm_max, and an overmodulation flag when the vector leaves the hexagon and the setpoints
// were clamped. A new vector is accepted every clock cycle unless a full queue stalls the
// front end. Two 34-stage pipelined dividers form the right and left on-time ratios. A
// four-entry queue between the classifying front end and the divider back end lets the input
// side keep accepting while a result waits at the output. Registers are to be written over the
// cfg port only while no vector is in flight (the block itself does not enforce this). Registers:
// 0 dc link voltage (0 acts as 1), 1 pulse period (no effect on results), 2 pwm_max.
// depends on svpwm_pkg, svpwm_front, svpwm_fifo, svpwm_back
`timescale 1ns / 1ps

module space_vector_pwm_setpoints (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // v_alpha, v_beta
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [55:0]                    m_axis_tdata,  // u_setpoint, v_setpoint, w_setpoint, sector
  output logic                           m_axis_tuser,  // overmodulated
  input  logic                           cfg_we_i,
  input  logic [svpwm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [svpwm_pkg::CfgW-1:0]     cfg_wdata_i
);

  logic [svpwm_pkg::DcW-1:0]   dc_q;
  logic [svpwm_pkg::SetW-1:0]  pwm_max_q;
  logic [svpwm_pkg::DcW-1:0]   dc_eff;
  logic [svpwm_pkg::DenW-1:0]  den;

  logic                        cls_valid, fifo_ready, q_valid, q_pop;
  svpwm_pkg::vec_class_t       cls, q_data;
  logic [svpwm_pkg::SetW-1:0]  u_sp, v_sp, w_sp;
  logic [svpwm_pkg::SecW-1:0]  sector;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q      <= 15'd6144;
      pwm_max_q <= 16'd4800;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        svpwm_pkg::CfgDcLink: dc_q      <= cfg_wdata_i[svpwm_pkg::DcW-1:0];
        svpwm_pkg::CfgPwmMax: pwm_max_q <= cfg_wdata_i;
        // period cancels out of every ratio
        svpwm_pkg::CfgPeriod: ;
        default: ;
      endcase
    end
  end

  assign dc_eff = (dc_q == '0) ? svpwm_pkg::DcW'(1) : dc_q;
  assign den    = {dc_eff, 1'b0};

  svpwm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .alpha_i     (s_axis_tdata[15:0]),
    .beta_i      (s_axis_tdata[31:16]),
    .cls_valid_o (cls_valid),
    .cls_ready_i (fifo_ready),
    .cls_o       (cls)
  );

  svpwm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cls_valid),
    .ready_o (fifo_ready),
    .data_i  (cls),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_data)
  );

  svpwm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .den_i       (den),
    .pwm_max_i   (pwm_max_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .u_o         (u_sp),
    .v_o         (v_sp),
    .w_o         (w_sp),
    .sector_o    (sector),
    .over_o      (m_axis_tuser)
  );

  assign m_axis_tdata = {5'b0, sector, w_sp, v_sp, u_sp};

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench for space_vector_pwm_setpoints: directed table, then random phases
// checked against a local setpoint predictor; depends on svpwm_pkg and the design top
`timescale 1ns / 1ps

module tb;

  localparam int     CycleLimit    = 200000;
  localparam int     NumPhases     = 9;
  localparam int     ItemsPerPhase = 160;
  localparam int     TailCycles    = 60;
  localparam longint FullPeriod    = 65536;
  localparam logic [svpwm_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef struct packed {
    logic [svpwm_pkg::SetW-1:0] u;
    logic [svpwm_pkg::SetW-1:0] v;
    logic [svpwm_pkg::SetW-1:0] w;
    logic [svpwm_pkg::SecW-1:0] sector;
    logic                       ovm;
  } setpoints_t;

  typedef enum logic [1:0] {RowVector, RowConfig} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [15:0] a;      // v_alpha, or register index
    logic [15:0] b;      // v_beta, or write data
    bit          known;
    setpoints_t  want;
  } stim_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [31:0]                     s_axis_tdata = '0;  // v_alpha, v_beta
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [55:0]                     m_axis_tdata;       // u_setpoint, v_setpoint, w_setpoint, sector
  logic                            m_axis_tuser;       // overmodulated
  logic                            cfg_we_i = 1'b0;
  logic [svpwm_pkg::CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [svpwm_pkg::CfgW-1:0]      cfg_wdata_i = '0;

  // local copy of the register file
  logic [svpwm_pkg::DcW-1:0]  dc_link_q = 15'd6144;
  logic [svpwm_pkg::CfgW-1:0] period_q  = 16'd1;
  logic [svpwm_pkg::SetW-1:0] pwm_max_q = 16'd4800;

  setpoints_t pending_setpoints[$];
  stim_row_t  directed_rows[$];
  bit         steady_flow = 1'b0;
  int         errors = 0;
  int         results_seen = 0;
  int         vectors_sent = 0;
  int         overmod_count = 0;
  int         cycles = 0;

  space_vector_pwm_setpoints DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic longint on_time(longint mag, longint dc);
    return (3 * mag * FullPeriod) / (2 * dc);
  endfunction

  function automatic logic [svpwm_pkg::SetW-1:0] scale_to_top(longint ratio, longint top);
    longint s;
    s = (top * ratio) / FullPeriod;
    if (s < 0) s = 0;
    if (s > top) s = top;
    return svpwm_pkg::SetW'(s);
  endfunction

  function automatic setpoints_t predict_setpoints(logic signed [15:0] alpha,
                                                   logic signed [15:0] beta);
    longint                     aa, bb, p, c, a, b, babs, ur, ul, dc, tr, tl, t0, top, mid;
    logic [svpwm_pkg::SetW-1:0] lo, md, hi;
    logic [svpwm_pkg::SecW-1:0] sec;
    setpoints_t                 r;
    aa   = alpha < 0 ? -longint'(alpha) : longint'(alpha);
    bb   = beta < 0 ? -longint'(beta) : longint'(beta);
    p    = (bb * longint'(svpwm_pkg::InvSqrt3Q16)) >> 16;
    c    = (bb * longint'(svpwm_pkg::TwoInvSqrt3Q16)) >> 16;
    a    = aa + p;
    b    = aa - p;
    babs = b < 0 ? -b : b;
    if (beta >= 0) begin
      if (alpha >= 0) sec = (b >= 0) ? svpwm_pkg::Sec1 : svpwm_pkg::Sec2;
      else sec = (b >= 0) ? svpwm_pkg::Sec3 : svpwm_pkg::Sec2;
    end else begin
      if (alpha >= 0) sec = (b >= 0) ? svpwm_pkg::Sec6 : svpwm_pkg::Sec5;
      else sec = (b >= 0) ? svpwm_pkg::Sec4 : svpwm_pkg::Sec5;
    end
    if (sec == svpwm_pkg::Sec1 || sec == svpwm_pkg::Sec4) begin
      ur = babs;
      ul = c;
    end else if (sec == svpwm_pkg::Sec3 || sec == svpwm_pkg::Sec6) begin
      ur = c;
      ul = babs;
    end else if ((sec == svpwm_pkg::Sec2 && alpha >= 0) ||
                 (sec == svpwm_pkg::Sec5 && alpha < 0)) begin
      ur = a;
      ul = babs;
    end else begin
      ur = babs;
      ul = a;
    end
    dc  = (dc_link_q == 0) ? 1 : longint'(dc_link_q);
    tr  = on_time(ur, dc);
    tl  = on_time(ul, dc);
    t0  = (FullPeriod - tr - tl) / 2;
    top = longint'(pwm_max_q);
    mid = (sec == svpwm_pkg::Sec1 || sec == svpwm_pkg::Sec3 || sec == svpwm_pkg::Sec5) ?
          t0 + tr : t0 + tl;
    lo  = scale_to_top(t0, top);
    md  = scale_to_top(mid, top);
    hi  = scale_to_top(FullPeriod - t0, top);
    case (sec)
      svpwm_pkg::Sec1: begin r.u = lo; r.v = md; r.w = hi; end
      svpwm_pkg::Sec2: begin r.v = lo; r.u = md; r.w = hi; end
      svpwm_pkg::Sec3: begin r.v = lo; r.w = md; r.u = hi; end
      svpwm_pkg::Sec4: begin r.w = lo; r.v = md; r.u = hi; end
      svpwm_pkg::Sec5: begin r.w = lo; r.u = md; r.v = hi; end
      default: begin r.u = lo; r.w = md; r.v = hi; end
    endcase
    r.sector = sec;
    r.ovm    = (tr + tl > FullPeriod);
    return r;
  endfunction

  function automatic stim_row_t row_vec(logic [15:0] a, logic [15:0] b);
    stim_row_t r;
    r.kind  = RowVector;
    r.a     = a;
    r.b     = b;
    r.known = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t row_known(logic [15:0] a, logic [15:0] b, int u, int v, int w,
                                          logic [svpwm_pkg::SecW-1:0] sec, logic ovm);
    stim_row_t r;
    r.kind        = RowVector;
    r.a           = a;
    r.b           = b;
    r.known       = 1'b1;
    r.want.u      = svpwm_pkg::SetW'(u);
    r.want.v      = svpwm_pkg::SetW'(v);
    r.want.w      = svpwm_pkg::SetW'(w);
    r.want.sector = sec;
    r.want.ovm    = ovm;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(logic [svpwm_pkg::CfgIdxW-1:0] idx,
                                        logic [svpwm_pkg::CfgW-1:0] data);
    stim_row_t r;
    r.kind  = RowConfig;
    r.a     = 16'(idx);
    r.b     = data;
    r.known = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  task automatic drive_vector(input logic [15:0] alpha, input logic [15:0] beta,
                              input bit known, input setpoints_t given);
    setpoints_t want;
    @(negedge clk_i);
    if (!steady_flow && $urandom_range(0, 99) < 3) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {beta, alpha};
    do @(posedge clk_i); while (!s_axis_tready);
    want = known ? given : predict_setpoints(alpha, beta);
    pending_setpoints.push_back(want);
    vectors_sent++;
    if (want.ovm) overmod_count++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_setpoints.size() != 0) @(negedge clk_i);
  endtask

  // every vector gives a result, so an empty queue means the pipeline is empty
  task automatic write_reg(input logic [svpwm_pkg::CfgIdxW-1:0] idx,
                           input logic [svpwm_pkg::CfgW-1:0] data);
    drain_results();
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      svpwm_pkg::CfgDcLink: dc_link_q = data[svpwm_pkg::DcW-1:0];
      svpwm_pkg::CfgPeriod: period_q  = data;
      svpwm_pkg::CfgPwmMax: pwm_max_q = data;
      default: ;
    endcase
  endtask

  task automatic pick_vector(output logic [15:0] alpha, output logic [15:0] beta);
    int dc, r, sa, sb, mode, pp;
    int extremes[5];
    extremes = '{-32768, -1, 0, 1, 32767};
    dc   = (dc_link_q == 0) ? 1 : int'(dc_link_q);
    mode = $urandom_range(0, 99);
    if (mode < 15) begin
      sa = $urandom;
      sb = $urandom;
    end else if (mode < 75) begin
      // mostly inside the hexagon, some just beyond it
      r  = (mode < 60) ? dc * 2 / 5 : dc * 3 / 5;
      if (r < 1) r = 1;
      sa = $urandom_range(0, 2 * r) - r;
      sb = $urandom_range(0, 2 * r) - r;
    end else if (mode < 85) begin
      // on or next to a sector border where |alpha| = |beta|/sqrt3
      sb = $urandom_range(0, 65535) - 32768;
      pp = ((sb < 0 ? -sb : sb) * 37837) >>> 16;
      sa = pp + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 1)) sa = -sa;
    end else if (mode < 92) begin
      sa = $urandom_range(0, 65535) - 32768;
      sb = -$urandom_range(0, 1);
      if ($urandom_range(0, 1)) begin
        pp = sa;
        sa = sb;
        sb = pp;
      end
    end else begin
      sa = extremes[$urandom_range(0, 4)];
      sb = extremes[$urandom_range(0, 4)];
    end
    alpha = sa[15:0];
    beta  = sb[15:0];
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= 6);
  end

  always @(posedge clk_i) begin
    setpoints_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_setpoints.size() == 0) begin
        report_mismatch("unexpected transaction, sector", m_axis_tdata[50:48], 0);
      end else begin
        want = pending_setpoints.pop_front();
        if (m_axis_tdata[15:0] != want.u) report_mismatch("u_setpoint", m_axis_tdata[15:0], want.u);
        if (m_axis_tdata[31:16] != want.v) report_mismatch("v_setpoint", m_axis_tdata[31:16], want.v);
        if (m_axis_tdata[47:32] != want.w) report_mismatch("w_setpoint", m_axis_tdata[47:32], want.w);
        if (m_axis_tdata[50:48] != want.sector)
          report_mismatch("sector", m_axis_tdata[50:48], want.sector);
        if (m_axis_tuser !== want.ovm) report_mismatch("overmodulated", m_axis_tuser, want.ovm);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("run stopped after %0d cycles, %0d results outstanding", cycles,
               pending_setpoints.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0]                va, vb;
    logic [svpwm_pkg::CfgW-1:0] dc_w, pm_w;
    // reset values: dc 6144, pwm_max 4800
    directed_rows.push_back(row_known(16'sd0, 16'sd0, 2400, 2400, 2400, svpwm_pkg::Sec1, 1'b0));
    directed_rows.push_back(row_known(16'sd32767, 16'sd0, 0, 4800, 4800, svpwm_pkg::Sec1, 1'b1));
    directed_rows.push_back(row_known(-16'sd32768, -16'sd32768, 4800, 4800, 0, svpwm_pkg::Sec4,
                                      1'b1));
    directed_rows.push_back(row_vec(16'sd1000, 16'sd300));
    directed_rows.push_back(row_vec(16'sd300, 16'sd1000));
    directed_rows.push_back(row_vec(-16'sd300, 16'sd1000));
    directed_rows.push_back(row_vec(-16'sd1000, 16'sd300));
    directed_rows.push_back(row_vec(-16'sd1000, -16'sd300));
    directed_rows.push_back(row_vec(-16'sd300, -16'sd1000));
    directed_rows.push_back(row_vec(16'sd300, -16'sd1000));
    directed_rows.push_back(row_vec(16'sd1000, -16'sd300));
    directed_rows.push_back(row_vec(-16'sd32768, 16'sd32767));
    directed_rows.push_back(row_vec(16'sd32767, -16'sd32768));
    directed_rows.push_back(row_vec(16'sd0, -16'sd32768));
    directed_rows.push_back(row_vec(-16'sd32768, 16'sd0));
    directed_rows.push_back(row_vec(-16'sd1, -16'sd1));
    // dc link of zero acts as one
    directed_rows.push_back(row_cfg(svpwm_pkg::CfgDcLink, 16'h0000));
    directed_rows.push_back(row_known(16'sd0, 16'sd0, 2400, 2400, 2400, svpwm_pkg::Sec1, 1'b0));
    directed_rows.push_back(row_known(16'sd1, 16'sd0, 0, 4800, 4800, svpwm_pkg::Sec1, 1'b1));
    // pwm_max of zero forces all setpoints low
    directed_rows.push_back(row_cfg(svpwm_pkg::CfgPwmMax, 16'h0000));
    directed_rows.push_back(row_vec(16'sd500, 16'sd200));
    directed_rows.push_back(row_vec(-16'sd32768, -16'sd32768));
    directed_rows.push_back(row_cfg(CfgUnused, 16'hFFFF));
    directed_rows.push_back(row_cfg(svpwm_pkg::CfgDcLink, 16'h7FFF));
    directed_rows.push_back(row_cfg(svpwm_pkg::CfgPeriod, 16'hFFFF));
    directed_rows.push_back(row_cfg(svpwm_pkg::CfgPwmMax, 16'hFFFF));
    directed_rows.push_back(row_vec(16'sd32767, 16'sd32767));
    directed_rows.push_back(row_vec(-16'sd20000, 16'sd5000));
    directed_rows.push_back(row_vec(16'sd1, -16'sd1));
    // bit 15 of the dc write is dropped
    directed_rows.push_back(row_cfg(svpwm_pkg::CfgDcLink, 16'hFFFF));
    directed_rows.push_back(row_cfg(svpwm_pkg::CfgPwmMax, 16'h0001));
    directed_rows.push_back(row_vec(16'sd9000, -16'sd4000));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowConfig) begin
        write_reg(directed_rows[i].a[svpwm_pkg::CfgIdxW-1:0], directed_rows[i].b);
      end else begin
        drive_vector(directed_rows[i].a, directed_rows[i].b, directed_rows[i].known,
                     directed_rows[i].want);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        1: dc_w = 16'd1;
        2: dc_w = 16'd32767;
        3: dc_w = 16'h8000;
        default: dc_w = svpwm_pkg::CfgW'($urandom_range(64, 32767)) |
                        (svpwm_pkg::CfgW'($urandom_range(0, 1)) << 15);
      endcase
      case (ph)
        2: pm_w = 16'hFFFF;
        4: pm_w = 16'd1;
        5: pm_w = 16'd0;
        default: pm_w = svpwm_pkg::CfgW'($urandom_range(1, 65535));
      endcase
      write_reg(svpwm_pkg::CfgDcLink, dc_w);
      write_reg(svpwm_pkg::CfgPeriod, svpwm_pkg::CfgW'($urandom));
      write_reg(svpwm_pkg::CfgPwmMax, pm_w);
      write_reg(CfgUnused, svpwm_pkg::CfgW'($urandom));
      steady_flow = (ph == 6);
      repeat (ItemsPerPhase) begin
        pick_vector(va, vb);
        drive_vector(va, vb, 1'b0, '0);
      end
    end

    steady_flow = 1'b0;
    drain_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("checked %0d results from %0d vectors (%0d overmodulated) over %0d register phases",
             results_seen, vectors_sent, overmod_count, NumPhases);
    $display("included dc link 0, 1 and 32767, pwm_max 0, 1 and 65535, all sectors and borders");
    if (errors == 0 && pending_setpoints.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
